// ===== sv/fzc_pkg.sv =====
// fzc_pkg: shared constants and types of the fuzzy rule table controller
// no dependencies; used by the result and configuration interfaces and the top level

package fzc_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_RULES_0_2  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RULES_3_5  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RULES_6    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_0_3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS_4_6 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_SPAN = 3'd5;

    localparam int RULES_ROWS_W = 63;
    localparam int RULES_ROW6_W = 21;
    localparam int LEVELS_LO_W  = 64;
    localparam int LEVELS_HI_W  = 48;
    localparam int SPAN_W       = 16;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 16'd100;

    // rule table geometry
    localparam int N_LABELS = 7;
    localparam int RULE_W   = 3;
    localparam int N_CELLS  = N_LABELS * N_LABELS;
    localparam logic [RULE_W-1:0] RULE_MAX = 3'd6;

    // scaled values in Q4.12: error scale 6, change scale 3
    localparam int FRAC_ONE = 4096;
    localparam int E_SCALE  = 6 * FRAC_ONE;
    localparam int C_SCALE  = 3 * FRAC_ONE;
    localparam int X_LIM    = 6 * FRAC_ONE;
    localparam int Q_W      = 15;           // quotient bits that can still be in range
    localparam int SEG_SHIFT = 13;          // segment width 2.0 in Q4.12
    localparam int U_W      = 16;           // offset value x + 6.0
    localparam int D_W      = 14;
    localparam int WGT_W    = 13;           // membership, Q1.12 up to 1.0
    localparam logic [D_W-1:0] SEG_ONE = 14'd8192;
    localparam logic [2:0] SEG_LAST  = 3'd6;
    localparam logic [2:0] SEG_CLAMP = 3'd5;

    // result
    localparam int DRIVE_W   = 24;
    localparam int DRIVE_MAX = 8388607;
    localparam int DRIVE_MIN = -8388608;
    localparam int OUT_SHIFT = 16;

    // one fuzzified input
    typedef struct packed {
        logic             ok;
        logic [2:0]       seg;
        logic [WGT_W-1:0] wl;
        logic [WGT_W-1:0] wr;
    } t_fuzz;

endpackage

// ===== sv/fzc_if.sv =====
// fzc_if: valid/ready channels of the fuzzy rule table controller
// depends on fzc_pkg for the result and configuration widths

interface fzc_sample_if #(parameter int INPUT_WIDTH = 16) ();
    logic                          valid;
    logic                          ready;
    logic signed [INPUT_WIDTH-1:0] error;
    logic signed [INPUT_WIDTH-1:0] error_delta;

    modport source (output valid, error, error_delta, input ready);
    modport sink   (input valid, error, error_delta, output ready);
endinterface

interface fzc_drive_if import fzc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] drive;

    modport source (output valid, drive, input ready);
    modport sink   (input valid, drive, output ready);
endinterface

interface fzc_cfg_if import fzc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== sv/fuzzy_rule_table_controller.sv =====
// fuzzy_rule_table_controller: two-input fuzzy controller, 7x7 rule table
// one beat per cycle sustained while o_result.ready stays high
// 15 of the stages are the bit-per-stage restoring dividers by the input span
// each stage holds its beat only while the next one is full and stalled
// synchronous active-low reset empties the pipeline and restores register defaults
// depends on fzc_pkg and fzc_if

module fuzzy_rule_table_controller import fzc_pkg::*; #(
    parameter int LEVEL_WIDTH = 16,
    parameter int INPUT_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    fzc_sample_if.sink    i_sample,
    fzc_drive_if.source   o_result,
    fzc_cfg_if.sink       i_cfg
);

    // pipeline geometry
    localparam int DIV_STEPS = Q_W;
    localparam int ST_PREP   = 0;
    localparam int ST_FUZZ   = DIV_STEPS + 1;
    localparam int ST_LUT    = DIV_STEPS + 2;
    localparam int ST_PROD   = DIV_STEPS + 3;
    localparam int ST_SUM    = DIV_STEPS + 4;
    localparam int ST_MUL    = DIV_STEPS + 5;
    localparam int ST_OUT    = DIV_STEPS + 6;
    localparam int N_ST      = DIV_STEPS + 7;

    // datapath widths
    localparam int NW    = INPUT_WIDTH + Q_W;       // scaled numerator magnitude
    localparam int P_W   = WGT_W + 1 + LEVEL_WIDTH; // weight times level
    localparam int S_W   = P_W + 1;
    localparam int M_W   = WGT_W + 1 + S_W;
    localparam int ACC_W = M_W + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(DRIVE_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(DRIVE_MIN);
    localparam logic signed [ACC_W-1:0] RND_NEG = ACC_W'((1 << OUT_SHIFT) - 1);

    // configuration registers
    logic [RULES_ROWS_W-1:0] r_rules_rows_0_2;
    logic [RULES_ROWS_W-1:0] r_rules_rows_3_5;
    logic [RULES_ROW6_W-1:0] r_rules_row_6;
    logic [LEVELS_LO_W-1:0]  r_levels_0_3;
    logic [LEVELS_HI_W-1:0]  r_levels_4_6;
    logic [SPAN_W-1:0]       r_range_span;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rules_rows_0_2 <= '0;
            r_rules_rows_3_5 <= '0;
            r_rules_row_6    <= '0;
            r_levels_0_3     <= '0;
            r_levels_4_6     <= '0;
            r_range_span     <= SPAN_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_RULES_0_2:  r_rules_rows_0_2 <= i_cfg.data[RULES_ROWS_W-1:0];
                CFG_RULES_3_5:  r_rules_rows_3_5 <= i_cfg.data[RULES_ROWS_W-1:0];
                CFG_RULES_6:    r_rules_row_6    <= i_cfg.data[RULES_ROW6_W-1:0];
                CFG_LEVELS_0_3: r_levels_0_3     <= i_cfg.data[LEVELS_LO_W-1:0];
                CFG_LEVELS_4_6: r_levels_4_6     <= i_cfg.data[LEVELS_HI_W-1:0];
                CFG_RANGE_SPAN: r_range_span     <= i_cfg.data[SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    // divisor, zero span taken as one
    logic [SPAN_W-1:0] w_div;
    assign w_div = (r_range_span == '0) ? SPAN_W'(1) : r_range_span;

    // flow control: a stage loads when empty or when its beat moves on
    logic [N_ST-1:0] r_vld;
    logic [N_ST-1:0] w_adv;

    assign w_adv[N_ST-1] = !r_vld[N_ST-1] || o_result.ready;
    for (genvar k = 0; k < N_ST - 1; k++) begin : g_adv
        assign w_adv[k] = !r_vld[k] || w_adv[k+1];
    end

    assign i_sample.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) begin
                r_vld[0] <= i_sample.valid;
            end
            for (int k = 1; k < N_ST; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // prep stage: magnitudes, scaled numerators, range overflow check
    logic [INPUT_WIDTH-1:0] w_mag_e;
    logic [INPUT_WIDTH-1:0] w_mag_c;
    logic [NW-1:0]          w_num_e;
    logic [NW-1:0]          w_num_c;

    assign w_mag_e = i_sample.error[INPUT_WIDTH-1]
                   ? (~i_sample.error + 1'b1) : i_sample.error;
    assign w_mag_c = i_sample.error_delta[INPUT_WIDTH-1]
                   ? (~i_sample.error_delta + 1'b1) : i_sample.error_delta;
    assign w_num_e = NW'(w_mag_e) * NW'(E_SCALE);
    assign w_num_c = NW'(w_mag_c) * NW'(C_SCALE);

    logic [SPAN_W-1:0] r_rem_e [0:DIV_STEPS-1];
    logic [SPAN_W-1:0] r_rem_c [0:DIV_STEPS-1];
    logic [Q_W-1:0]    r_low_e [0:DIV_STEPS-1];
    logic [Q_W-1:0]    r_low_c [0:DIV_STEPS-1];
    logic [Q_W-1:0]    r_q_e   [1:DIV_STEPS];
    logic [Q_W-1:0]    r_q_c   [1:DIV_STEPS];
    logic              r_neg_e [0:DIV_STEPS];
    logic              r_neg_c [0:DIV_STEPS];
    logic              r_ovf_e [0:DIV_STEPS];
    logic              r_ovf_c [0:DIV_STEPS];

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_PREP]) begin
            r_rem_e[0] <= SPAN_W'(w_num_e[NW-1:Q_W]);
            r_rem_c[0] <= SPAN_W'(w_num_c[NW-1:Q_W]);
            r_low_e[0] <= w_num_e[Q_W-1:0];
            r_low_c[0] <= w_num_c[Q_W-1:0];
            r_neg_e[0] <= i_sample.error[INPUT_WIDTH-1];
            r_neg_c[0] <= i_sample.error_delta[INPUT_WIDTH-1];
            r_ovf_e[0] <= (SPAN_W'(w_num_e[NW-1:Q_W]) >= w_div);
            r_ovf_c[0] <= (SPAN_W'(w_num_c[NW-1:Q_W]) >= w_div);
        end
    end

    // restoring divider, one quotient bit per stage for each input
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        logic [SPAN_W:0] w_te;
        logic [SPAN_W:0] w_tc;
        logic            w_ge_e;
        logic            w_ge_c;

        assign w_te   = {r_rem_e[j], r_low_e[j][Q_W-1]};
        assign w_tc   = {r_rem_c[j], r_low_c[j][Q_W-1]};
        assign w_ge_e = (w_te >= {1'b0, w_div});
        assign w_ge_c = (w_tc >= {1'b0, w_div});

        always_ff @(posedge i_clk) begin
            if (w_adv[j+1]) begin
                r_neg_e[j+1] <= r_neg_e[j];
                r_neg_c[j+1] <= r_neg_c[j];
                r_ovf_e[j+1] <= r_ovf_e[j];
                r_ovf_c[j+1] <= r_ovf_c[j];
            end
        end

        if (j == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_adv[j+1]) begin
                    r_q_e[j+1] <= Q_W'(w_ge_e);
                    r_q_c[j+1] <= Q_W'(w_ge_c);
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (w_adv[j+1]) begin
                    r_q_e[j+1] <= {r_q_e[j][Q_W-2:0], w_ge_e};
                    r_q_c[j+1] <= {r_q_c[j][Q_W-2:0], w_ge_c};
                end
            end
        end

        if (j < DIV_STEPS - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (w_adv[j+1]) begin
                    r_rem_e[j+1] <= w_ge_e ? SPAN_W'(w_te - {1'b0, w_div})
                                           : w_te[SPAN_W-1:0];
                    r_rem_c[j+1] <= w_ge_c ? SPAN_W'(w_tc - {1'b0, w_div})
                                           : w_tc[SPAN_W-1:0];
                    r_low_e[j+1] <= {r_low_e[j][Q_W-2:0], 1'b0};
                    r_low_c[j+1] <= {r_low_c[j][Q_W-2:0], 1'b0};
                end
            end
        end
    end

    // segment and left/right memberships of one scaled value
    function automatic t_fuzz fuzzify(input logic [Q_W-1:0] q, input logic neg,
                                      input logic ovf);
        t_fuzz          f;
        logic [U_W-1:0] u;
        logic [2:0]     s;
        logic [D_W-1:0] d;
        u = neg ? (U_W'(X_LIM) - U_W'(q)) : (U_W'(X_LIM) + U_W'(q));
        s = u[U_W-1:SEG_SHIFT];
        // exactly +6 belongs to the last segment
        if (s == SEG_LAST) begin
            s = SEG_CLAMP;
            d = SEG_ONE;
        end else begin
            d = D_W'(u[SEG_SHIFT-1:0]);
        end
        f.ok  = !ovf && (q <= Q_W'(X_LIM));
        f.seg = s;
        f.wr  = WGT_W'(d >> 1);
        f.wl  = WGT_W'((SEG_ONE - d) >> 1);
        return f;
    endfunction

    // fuzzify stage
    t_fuzz r_fz_e;
    t_fuzz r_fz_c;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_FUZZ]) begin
            r_fz_e <= fuzzify(r_q_e[DIV_STEPS], r_neg_e[DIV_STEPS], r_ovf_e[DIV_STEPS]);
            r_fz_c <= fuzzify(r_q_c[DIV_STEPS], r_neg_c[DIV_STEPS], r_ovf_c[DIV_STEPS]);
        end
    end

    // rule table and level lookup
    logic [RULE_W*N_CELLS-1:0]     w_rules;
    logic signed [LEVEL_WIDTH-1:0] w_level [0:N_LABELS-1];

    assign w_rules = {r_rules_row_6, r_rules_rows_3_5, r_rules_rows_0_2};

    for (genvar k = 0; k < N_LABELS; k++) begin : g_level
        if (k < 4) begin : g_lo
            assign w_level[k] = r_levels_0_3[k*LEVEL_WIDTH +: LEVEL_WIDTH];
        end else begin : g_hi
            assign w_level[k] = r_levels_4_6[(k-4)*LEVEL_WIDTH +: LEVEL_WIDTH];
        end
    end

    function automatic logic [RULE_W-1:0] rule_of(input logic [RULE_W*N_CELLS-1:0] rules,
                                                  input logic [2:0] row,
                                                  input logic [2:0] col);
        logic [5:0]        n;
        logic [7:0]        base;
        logic [RULE_W-1:0] r;
        n    = 6'(row) * 6'd7 + 6'(col);
        base = 8'(n) * 8'd3;
        r    = rules[base +: RULE_W];
        // entry seven saturates to the top level
        return (r > RULE_MAX) ? RULE_MAX : r;
    endfunction

    logic signed [LEVEL_WIDTH-1:0] r_lv00, r_lv01, r_lv10, r_lv11;
    logic [WGT_W-1:0]              r_lut_el, r_lut_er, r_lut_cl, r_lut_cr;
    logic                          r_lut_ok;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_LUT]) begin
            r_lv00   <= w_level[rule_of(w_rules, r_fz_e.seg, r_fz_c.seg)];
            r_lv01   <= w_level[rule_of(w_rules, r_fz_e.seg, r_fz_c.seg + 3'd1)];
            r_lv10   <= w_level[rule_of(w_rules, r_fz_e.seg + 3'd1, r_fz_c.seg)];
            r_lv11   <= w_level[rule_of(w_rules, r_fz_e.seg + 3'd1, r_fz_c.seg + 3'd1)];
            r_lut_el <= r_fz_e.wl;
            r_lut_er <= r_fz_e.wr;
            r_lut_cl <= r_fz_c.wl;
            r_lut_cr <= r_fz_c.wr;
            r_lut_ok <= r_fz_e.ok && r_fz_c.ok;
        end
    end

    // change memberships times levels
    logic signed [P_W-1:0] r_p00, r_p01, r_p10, r_p11;
    logic [WGT_W-1:0]      r_prod_el, r_prod_er;
    logic                  r_prod_ok;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_PROD]) begin
            r_p00     <= $signed({1'b0, r_lut_cl}) * r_lv00;
            r_p01     <= $signed({1'b0, r_lut_cr}) * r_lv01;
            r_p10     <= $signed({1'b0, r_lut_cl}) * r_lv10;
            r_p11     <= $signed({1'b0, r_lut_cr}) * r_lv11;
            r_prod_el <= r_lut_el;
            r_prod_er <= r_lut_er;
            r_prod_ok <= r_lut_ok;
        end
    end

    // row sums
    logic signed [S_W-1:0] r_sa, r_sb;
    logic [WGT_W-1:0]      r_sum_el, r_sum_er;
    logic                  r_sum_ok;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_SUM]) begin
            r_sa     <= S_W'(r_p00) + S_W'(r_p01);
            r_sb     <= S_W'(r_p10) + S_W'(r_p11);
            r_sum_el <= r_prod_el;
            r_sum_er <= r_prod_er;
            r_sum_ok <= r_prod_ok;
        end
    end

    // error memberships times row sums
    logic signed [M_W-1:0] r_m0, r_m1;
    logic                  r_mul_ok;

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_MUL]) begin
            r_m0     <= $signed({1'b0, r_sum_el}) * r_sa;
            r_m1     <= $signed({1'b0, r_sum_er}) * r_sb;
            r_mul_ok <= r_sum_ok;
        end
    end

    // final sum, truncation toward zero to Q16.8, saturation, zero when an input is out of range
    logic signed [ACC_W-1:0]   w_acc;
    logic signed [ACC_W-1:0]   w_shr;
    logic signed [DRIVE_W-1:0] w_drive;
    logic signed [DRIVE_W-1:0] r_drive;

    always_comb begin
        w_acc = ACC_W'(r_m0) + ACC_W'(r_m1);
        if (w_acc < 0) begin
            w_shr = (w_acc + RND_NEG) >>> OUT_SHIFT;
        end else begin
            w_shr = w_acc >>> OUT_SHIFT;
        end
        if (!r_mul_ok) begin
            w_drive = '0;
        end else if (w_shr > SAT_HI) begin
            w_drive = DRIVE_W'(SAT_HI);
        end else if (w_shr < SAT_LO) begin
            w_drive = DRIVE_W'(SAT_LO);
        end else begin
            w_drive = w_shr[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[ST_OUT]) begin
            r_drive <= w_drive;
        end
    end

    assign o_result.valid = r_vld[ST_OUT];
    assign o_result.drive = r_drive;

endmodule
